// File: rtl/rdc_pkg.sv
// Shared types, constants and the digit character lookup for the radix digit converter.
package rdc_pkg;

  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam int DIV_STEP_BITS = 8;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  radix;
  } rdc_in_t;

  typedef struct packed {
    logic [6:0] digit_char;
    logic [5:0] digit_count;
    logic       last_digit;
  } rdc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WAIT,
    ST_PREP,
    ST_EMIT
  } rdc_state_t;

  function automatic logic [6:0] digit_ascii(input logic [5:0] d);
    logic [5:0] dd;
    logic [6:0] ch;
    dd = (d >= RADIX_MAX) ? d - RADIX_MAX : d;
    if (dd < 6'd10) begin
      ch = 7'h30 + {1'b0, dd};
    end else begin
      ch = 7'h41 + {1'b0, dd} - 7'd10;
    end
    return ch;
  endfunction

endpackage

// File: rtl/rdc_divider.sv
// Iterative divider that divides a value by a small radix, eight quotient bits per cycle.
module rdc_divider import rdc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [5:0]             radix,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [5:0]             remainder
);

  localparam int NCH = (VALUE_WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int PW  = NCH * DIV_STEP_BITS;
  localparam int CW  = $clog2(NCH + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] q_r;
  logic [5:0]    rem_r;
  logic [5:0]    rad_r;

  logic [PW-1:0]            q_nxt;
  logic [5:0]               rem_nxt;
  logic [PW+VALUE_WIDTH-1:0] dividend_ext;

  assign dividend_ext = {{PW{1'b0}}, dividend};

  always_comb begin
    logic [6:0]               t;
    logic [5:0]               r;
    logic [DIV_STEP_BITS-1:0] qbits;
    r = rem_r;
    qbits = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      t = {r, q_r[PW-1-i]};
      if (t >= {1'b0, rad_r}) begin
        r = 6'(t - {1'b0, rad_r});
        qbits[DIV_STEP_BITS-1-i] = 1'b1;
      end else begin
        r = t[5:0];
      end
    end
    rem_nxt = r;
    q_nxt   = PW'({q_r, qbits});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NCH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend_ext[PW-1:0];
      rem_r <= '0;
      rad_r <= radix;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r[VALUE_WIDTH-1:0];
  assign remainder = rem_r;

endmodule

// File: rtl/rdc_digit_buf.sv
// Digit store with one write port and one registered read port.
module rdc_digit_buf import rdc_pkg::*; #(
  parameter int MAX_DIGITS = 32
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_DIGITS)-1:0] wr_addr,
  input  logic [5:0]                    wr_data,
  input  logic [$clog2(MAX_DIGITS)-1:0] rd_addr,
  output logic [5:0]                    rd_data
);

  logic [5:0] mem [MAX_DIGITS];
  logic [5:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/radix_digit_converter_core.sv
// Top level of the radix digit converter: sequencer, divider and digit store.
//
// A transaction is taken when start is high and busy is low. The block then
// divides the value by the clamped radix once per digit in the shared divider
// and stores the remainders. It then emits one digit per cycle, most
// significant first, after a PREP state that primes the store read. Each digit
// appears on out_data for exactly one cycle with out_valid high and the
// receiver must take it then.
module radix_digit_converter_core import rdc_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rdc_in_t  in_data,
  output logic     out_valid,
  output rdc_out_t out_data
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  rdc_state_t             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] work_r, work_nxt;
  logic [5:0]             radix_r, radix_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       left_r, left_nxt;
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;

  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [5:0]             div_rem;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [5:0]             wr_data;
  logic [IDX_W-1:0]       rd_addr;
  logic [5:0]             rd_data;

  logic [VALUE_WIDTH+31:0] value_ext;
  logic [VALUE_WIDTH-1:0]  value_in;
  logic [5:0]              radix_in;
  logic [CNT_W-1:0]        count_m1;
  logic [CNT_W+5:0]        count_ext;
  logic                    last_div;

  assign value_ext = {{VALUE_WIDTH{1'b0}}, in_data.value};
  assign value_in  = value_ext[VALUE_WIDTH-1:0];
  assign count_m1  = count_r - CNT_W'(1);
  assign count_ext = {6'b0, count_r};
  assign last_div  = (div_quot == '0) || (count_r == CNT_W'(MAX_DIGITS - 1));

  always_comb begin
    if (in_data.radix < RADIX_MIN) begin
      radix_in = RADIX_MIN;
    end else if (in_data.radix > RADIX_MAX) begin
      radix_in = RADIX_MAX;
    end else begin
      radix_in = in_data.radix;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (value_in == '0) ? ST_PREP : ST_DIV;
        end
      end
      ST_DIV: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          state_nxt = last_div ? ST_PREP : ST_DIV;
        end
      end
      ST_PREP: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (left_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    work_nxt   = work_r;
    radix_nxt  = radix_r;
    count_nxt  = count_r;
    left_nxt   = left_r;
    rd_idx_nxt = rd_idx_r;
    div_start  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = count_r[IDX_W-1:0];
    wr_data    = div_rem;
    rd_addr    = rd_idx_r;
    out_valid  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          work_nxt  = value_in;
          radix_nxt = radix_in;
          if (value_in == '0) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = '0;
            count_nxt = CNT_W'(1);
          end else begin
            count_nxt = '0;
          end
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
      end
      ST_WAIT: begin
        if (div_done) begin
          wr_en     = 1'b1;
          work_nxt  = div_quot;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ST_PREP: begin
        rd_addr    = count_m1[IDX_W-1:0];
        rd_idx_nxt = count_m1[IDX_W-1:0] - IDX_W'(1);
        left_nxt   = count_r;
      end
      ST_EMIT: begin
        out_valid  = 1'b1;
        rd_idx_nxt = rd_idx_r - IDX_W'(1);
        left_nxt   = left_r - CNT_W'(1);
      end
      default: begin
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      work_r   <= '0;
      radix_r  <= RADIX_MIN;
      count_r  <= '0;
      left_r   <= '0;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      work_r   <= work_nxt;
      radix_r  <= radix_nxt;
      count_r  <= count_nxt;
      left_r   <= left_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  rdc_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (work_r),
    .radix     (radix_r),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  rdc_digit_buf #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_digit_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy                 = (state_r != ST_IDLE);
  assign out_data.digit_char  = digit_ascii(rd_data);
  assign out_data.digit_count = count_ext[5:0];
  assign out_data.last_digit  = (left_r == CNT_W'(1));

endmodule
